// ===== rtl/b2rne_pkg.sv =====
package b2rne_pkg;

  localparam int unsigned ValueW   = 16;
  localparam int unsigned RestW    = 12;
  localparam int unsigned CharW    = 7;
  localparam int unsigned NumTerms = 13;
  localparam int unsigned TermW    = 4;

  localparam logic [ValueW-1:0] MaxValue = 16'd3999;
  localparam logic [CharW-1:0]  CharNone = 7'd0;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic step_last;
  } sts_t;

  function automatic logic [RestW-1:0] term_amount(input logic [TermW-1:0] idx);
    logic [RestW-1:0] amt;
    unique case (idx)
      4'd0:    amt = 12'd1000;
      4'd1:    amt = 12'd900;
      4'd2:    amt = 12'd500;
      4'd3:    amt = 12'd400;
      4'd4:    amt = 12'd100;
      4'd5:    amt = 12'd90;
      4'd6:    amt = 12'd50;
      4'd7:    amt = 12'd40;
      4'd8:    amt = 12'd10;
      4'd9:    amt = 12'd9;
      4'd10:   amt = 12'd5;
      4'd11:   amt = 12'd4;
      default: amt = 12'd1;
    endcase
    return amt;
  endfunction

  function automatic logic [CharW-1:0] term_first(input logic [TermW-1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      4'd0:             c = 7'h4D;
      4'd1, 4'd3, 4'd4: c = 7'h43;
      4'd2:             c = 7'h44;
      4'd5, 4'd7, 4'd8: c = 7'h58;
      4'd6:             c = 7'h4C;
      4'd10:            c = 7'h56;
      default:          c = 7'h49;
    endcase
    return c;
  endfunction

  function automatic logic [CharW-1:0] term_second(input logic [TermW-1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      4'd1:    c = 7'h4D;
      4'd3:    c = 7'h44;
      4'd5:    c = 7'h43;
      4'd7:    c = 7'h4C;
      4'd9:    c = 7'h58;
      4'd11:   c = 7'h56;
      default: c = CharNone;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/binary_to_roman_numeral_encoder_unit.sv =====
// Roman numeral encoder.
// Input channel: value_i with in_valid_i / in_stall_o. A transaction carries one
// unsigned 16-bit number; values 1 to 3999 are encoded.
// Output channel: char_code_o, last_char_o, range_error_o with out_valid_o /
// out_stall_i. Each transaction carries one ASCII letter (I V X L C D M), most
// significant first; last_char_o marks the final letter of a numeral. Zero or a
// value above 3999 gives a single transaction with range_error_o and
// last_char_o set and char_code_o zero.
// Flow: an accepted number is loaded into the remainder register, then the
// controller steps the letter register; letters follow one per cycle from it
// while the output is not stalled (3888 gives the longest numeral). The next
// number is taken in the cycle after the final letter is produced, while it waits.
// Throughput is set by the single letter register the controller steps.
// A stall on the output holds the current letter and pauses encoding.
// Reset clears the controller and output valid; no output is pending after it.
module binary_to_roman_numeral_encoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [b2rne_pkg::ValueW-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [b2rne_pkg::CharW-1:0]   char_code_o,
  output logic                          last_char_o,
  output logic                          range_error_o
);
  import b2rne_pkg::*;

  cmd_t cmd;
  sts_t sts;

  b2rne_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  b2rne_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_code_o   (char_code_o),
    .last_char_o   (last_char_o),
    .range_error_o (range_error_o)
  );

endmodule

// ===== rtl/b2rne_ctrl.sv =====
module b2rne_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  b2rne_pkg::sts_t sts_i,
  output b2rne_pkg::cmd_t cmd_o
);
  import b2rne_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StRun;
      end
      StRun: begin
        if (sts_i.out_free && sts_i.step_last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      StRun: begin
        cmd_o.step = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/b2rne_dp.sv =====
module b2rne_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  b2rne_pkg::cmd_t               cmd_i,
  output b2rne_pkg::sts_t               sts_o,
  input  logic [b2rne_pkg::ValueW-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [b2rne_pkg::CharW-1:0]   char_code_o,
  output logic                          last_char_o,
  output logic                          range_error_o
);
  import b2rne_pkg::*;

  logic [RestW-1:0] rest_q, rest_d;
  logic [CharW-1:0] second_q, second_d;
  logic             pend_q, pend_d;
  logic             err_q, err_d;
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;
  logic             rerr_q, rerr_d;

  logic [TermW-1:0] sel;
  logic [RestW-1:0] rest_sub;
  logic [CharW-1:0] sel_second;

  always_comb begin
    sel = TermW'(NumTerms - 1);
    for (int i = NumTerms - 1; i >= 0; i--) begin
      if (rest_q >= term_amount(TermW'(i))) sel = TermW'(i);
    end
  end

  assign rest_sub   = rest_q - term_amount(sel);
  assign sel_second = term_second(sel);

  always_comb begin
    rest_d   = rest_q;
    second_d = second_q;
    pend_d   = pend_q;
    err_d    = err_q;
    char_d   = char_q;
    last_d   = last_q;
    rerr_d   = rerr_q;
    if (cmd_i.load) begin
      rest_d = value_i[RestW-1:0];
      err_d  = (value_i == '0) || (value_i > MaxValue);
      pend_d = 1'b0;
    end else if (cmd_i.step) begin
      priority if (err_q) begin
        char_d = CharNone;
        last_d = 1'b1;
        rerr_d = 1'b1;
      end else if (pend_q) begin
        char_d = second_q;
        last_d = (rest_q == '0);
        rerr_d = 1'b0;
        pend_d = 1'b0;
      end else begin
        char_d   = term_first(sel);
        rerr_d   = 1'b0;
        rest_d   = rest_sub;
        second_d = sel_second;
        pend_d   = (sel_second != CharNone);
        last_d   = (sel_second == CharNone) && (rest_sub == '0);
      end
    end
  end

  always_comb begin
    sts_o.step_last = last_d;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
    if (cmd_i.step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      err_q       <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q   <= rest_d;
    second_q <= second_d;
    char_q   <= char_d;
    last_q   <= last_d;
    rerr_q   <= rerr_d;
  end

  assign out_valid_o   = out_valid_q;
  assign char_code_o   = char_q;
  assign last_char_o   = last_q;
  assign range_error_o = rerr_q;

`ifndef ASSERT_OFF
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> (char_code_o == CharNone) && last_char_o)
    else $error("error result carries a letter");

  a_pend_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !err_q)
    else $error("second letter pending on an error transaction");

  a_step_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && !pend_q && !err_q |-> rest_q != '0)
    else $error("letter step with nothing left to encode");
`endif

endmodule

// ===== sim/tb.sv =====
module tb;
  import b2rne_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
    logic             err;
  } letter_t;

  typedef struct {
    logic [ValueW-1:0] number;
    bit                drain_first;
  } number_item_t;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DirectCount = 25;
  localparam int unsigned RandomCount = 355;
  localparam int unsigned CalmStart   = 1500;
  localparam int unsigned CalmEnd     = 3000;
  localparam int unsigned TailCycles  = 20;

  localparam logic [CharW-1:0] LtrI = 7'h49;
  localparam logic [CharW-1:0] LtrV = 7'h56;
  localparam logic [CharW-1:0] LtrX = 7'h58;
  localparam logic [CharW-1:0] LtrL = 7'h4C;
  localparam logic [CharW-1:0] LtrC = 7'h43;
  localparam logic [CharW-1:0] LtrD = 7'h44;
  localparam logic [CharW-1:0] LtrM = 7'h4D;

  localparam int unsigned NumeralAmount [13] = '{
    1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
  };
  localparam logic [CharW-1:0] LeadLetter [13] = '{
    LtrM, LtrC, LtrD, LtrC, LtrC, LtrX, LtrL, LtrX, LtrX, LtrI, LtrV, LtrI, LtrI
  };
  localparam logic [CharW-1:0] TailLetter [13] = '{
    CharNone, LtrM, CharNone, LtrD, CharNone, LtrC, CharNone, LtrL, CharNone,
    LtrX, CharNone, LtrV, CharNone
  };

  localparam logic [ValueW-1:0] DirectValue [DirectCount] = '{
    16'd1, 16'd3999, 16'd0, 16'd4000, 16'd65535, 16'd3888, 16'd4, 16'd9,
    16'd40, 16'd90, 16'd400, 16'd900, 16'd1000, 16'd500, 16'd100, 16'd50,
    16'd10, 16'd5, 16'd14, 16'd49, 16'd1994, 16'd444, 16'd2024, 16'd3, 16'd32768
  };

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [ValueW-1:0] value_i       = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [CharW-1:0]  char_code_o;
  logic              last_char_o;
  logic              range_error_o;

  number_item_t number_queue [$];
  letter_t      pending_letters [$];

  int unsigned cycle_count     = 0;
  int unsigned mismatch_count  = 0;
  int unsigned numbers_sent    = 0;
  int unsigned letters_checked = 0;
  int unsigned range_errors    = 0;

  binary_to_roman_numeral_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_code_o   (char_code_o),
    .last_char_o   (last_char_o),
    .range_error_o (range_error_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic bit take_break();
    if (cycle_count >= CalmStart && cycle_count < CalmEnd) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 20;
  endfunction

  function automatic logic [ValueW-1:0] random_number();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      return ValueW'($urandom_range(1, 3999));
    end else if (pick < 85) begin
      return '0;
    end
    return ValueW'($urandom_range(4000, 65535));
  endfunction

  function automatic void predict_numeral(input logic [ValueW-1:0] number);
    letter_t     spelled [$];
    letter_t     ltr;
    int unsigned rest;
    if (number == '0 || number > MaxValue) begin
      ltr = '{code: CharNone, last: 1'b1, err: 1'b1};
      pending_letters = {pending_letters, ltr};
      return;
    end
    rest = number;
    for (int t = 0; t < 13; t++) begin
      while (rest >= NumeralAmount[t]) begin
        ltr = '{code: LeadLetter[t], last: 1'b0, err: 1'b0};
        spelled = {spelled, ltr};
        if (TailLetter[t] != CharNone) begin
          ltr.code = TailLetter[t];
          spelled = {spelled, ltr};
        end
        rest -= NumeralAmount[t];
      end
    end
    spelled[spelled.size()-1].last = 1'b1;
    pending_letters = {pending_letters, spelled};
  endfunction

  always @(posedge clk_i) begin : driver
    number_item_t head;
    logic         next_valid;
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predict_numeral(value_i);
        numbers_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid && number_queue.size() > 0 && !take_break() &&
          !(number_queue[0].drain_first && pending_letters.size() > 0)) begin
        head = number_queue.pop_front();
        value_i <= head.number;
        next_valid = 1'b1;
      end
      in_valid_i <= next_valid;
    end
  end

  always @(posedge clk_i) begin : monitor
    letter_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_letters.size() == 0) begin
          report_mismatch($sformatf("unexpected letter 0x%0h", char_code_o));
        end else begin
          want = pending_letters.pop_front();
          letters_checked++;
          if (range_error_o) range_errors++;
          if (char_code_o !== want.code) begin
            report_mismatch($sformatf("char_code 0x%0h, want 0x%0h", char_code_o, want.code));
          end
          if (last_char_o !== want.last) begin
            report_mismatch($sformatf("last_char %0b, want %0b", last_char_o, want.last));
          end
          if (range_error_o !== want.err) begin
            report_mismatch($sformatf("range_error %0b, want %0b", range_error_o, want.err));
          end
        end
      end
      out_stall_i <= take_break();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    number_item_t item;
    for (int i = 0; i < DirectCount; i++) begin
      item.number      = DirectValue[i];
      item.drain_first = (i == 12);
      number_queue     = {number_queue, item};
    end
    for (int i = 0; i < RandomCount; i++) begin
      item.number      = random_number();
      item.drain_first = (i == 180);
      number_queue     = {number_queue, item};
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (number_queue.size() > 0 || in_valid_i || pending_letters.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (pending_letters.size() != 0) begin
      report_mismatch($sformatf("%0d letters never arrived", pending_letters.size()));
    end

    $display("Encoded %0d numbers into %0d checked letters, %0d of them range errors.",
             numbers_sent, letters_checked, range_errors);
    $display("Mismatches: %0d over %0d cycles.", mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
